### hw/rtl/depth_pixel_backprojection_core_defines.svh
// assertion macros used by the back-projection core
`ifndef DEPTH_PIXEL_BACKPROJECTION_CORE_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_CORE_DEFINES_SVH

// same-cycle implication, clocked by clk, off while arst_n is low
`define DPB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked by clk, off while arst_n is low
`define DPB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/dpb_pkg.sv
// types, widths and register codes of the depth back-projection core
package dpb_pkg;

	localparam int COORD_W    = 12;
	localparam int DEPTH_W    = 16;
	localparam int COLOR_W    = 8;
	localparam int RECIP_W    = 24;
	localparam int PP_W       = 16;
	localparam int POSE_W     = 64;
	localparam int ENT_W      = 16;
	localparam int WORLD_W    = 32;
	localparam int SPREAD_W   = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;
	localparam int NUM_ROWS   = 3;

	// camera-space datapath widths
	localparam int DIFF_W = 18;                 // col*16 - cx, signed
	localparam int P1_W   = 42;                 // diff * reciprocal
	localparam int P2_W   = 58;                 // diff * reciprocal * depth
	localparam int XY_SH  = 20;
	localparam int XC_W   = 37;                 // camera x/y in Q.8
	localparam int ZC_W   = DEPTH_W + 8;        // camera z in Q.8
	// world transform widths
	localparam int PR_W   = ENT_W + XC_W;
	localparam int PZ_W   = ENT_W + ZC_W + 1;
	localparam int ACC_W  = 55;
	localparam int W_SH   = 14;
	localparam int T_SH   = 22;
	localparam int WR_W   = ACC_W - W_SH;
	// spread term widths
	localparam int SA_W   = DEPTH_W + RECIP_W;
	localparam int S_SH   = 12;
	localparam int S_W    = SA_W - S_SH;
	localparam int SQ_W   = 2 * S_W;
	localparam int SQ_SH  = 8;
	localparam int SQR_W  = SQ_W - SQ_SH;

	localparam logic signed [P2_W-1:0]  XY_RND = P2_W'(524288);
	localparam logic signed [ACC_W-1:0] W_RND  = ACC_W'(8192);
	localparam logic [SA_W-1:0]         S_RND  = SA_W'(2048);
	localparam logic [SQ_W-1:0]         SQ_RND = SQ_W'(128);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_FOCAL_X     = 4'd0,
		REG_INV_FOCAL_Y     = 4'd1,
		REG_PRINCIPAL_POINT = 4'd2,
		REG_POSE_ROW_X      = 4'd3,
		REG_POSE_ROW_Y      = 4'd4,
		REG_POSE_ROW_Z      = 4'd5,
		REG_INV_AVG_FOCAL   = 4'd6,
		REG_SPREAD_ENABLE   = 4'd7
	} reg_idx_t;

	localparam logic [RECIP_W-1:0] RST_INV_FOCAL = RECIP_W'(33554);
	localparam logic [POSE_W-1:0]  RST_POSE_X    = 64'h0000_0000_0000_4000;
	localparam logic [POSE_W-1:0]  RST_POSE_Y    = 64'h0000_0000_4000_0000;
	localparam logic [POSE_W-1:0]  RST_POSE_Z    = 64'h0000_4000_0000_0000;

	typedef struct packed {
		logic [RECIP_W-1:0] inv_focal_x;
		logic [RECIP_W-1:0] inv_focal_y;
		logic [PP_W-1:0]    cy;
		logic [PP_W-1:0]    cx;
		logic [POSE_W-1:0]  pose_row_x;
		logic [POSE_W-1:0]  pose_row_y;
		logic [POSE_W-1:0]  pose_row_z;
		logic [RECIP_W-1:0] inv_avg_focal;
		logic               spread_enable;
	} cfg_t;

	typedef struct packed {
		logic signed [XC_W-1:0] xc;
		logic signed [XC_W-1:0] yc;
		logic [DEPTH_W-1:0]     d;
		logic [COLOR_W-1:0]     red;
		logic [COLOR_W-1:0]     green;
		logic [COLOR_W-1:0]     blue;
		logic [SQ_W-1:0]        sq_raw;
	} cam_t;

endpackage

### hw/rtl/dpb_pixel_if.sv
// pixel request channel
interface dpb_pixel_if import dpb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_col;
	logic [COORD_W-1:0] pixel_row;
	logic [DEPTH_W-1:0] depth_value;
	logic               mask_bit;
	logic [COLOR_W-1:0] color_red;
	logic [COLOR_W-1:0] color_green;
	logic [COLOR_W-1:0] color_blue;

	modport source (
		output valid, pixel_col, pixel_row, depth_value, mask_bit,
		output color_red, color_green, color_blue,
		input  ready
	);
	modport sink (
		input  valid, pixel_col, pixel_row, depth_value, mask_bit,
		input  color_red, color_green, color_blue,
		output ready
	);
endinterface

### hw/rtl/dpb_point_if.sv
// world point request channel
interface dpb_point_if import dpb_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [WORLD_W-1:0] world_x;
	logic signed [WORLD_W-1:0] world_y;
	logic signed [WORLD_W-1:0] world_z;
	logic [COLOR_W-1:0]        out_red;
	logic [COLOR_W-1:0]        out_green;
	logic [COLOR_W-1:0]        out_blue;
	logic [SPREAD_W-1:0]       spread_sq;

	modport source (
		output valid, world_x, world_y, world_z, out_red, out_green, out_blue,
		output spread_sq,
		input  ready
	);
	modport sink (
		input  valid, world_x, world_y, world_z, out_red, out_green, out_blue,
		input  spread_sq,
		output ready
	);
endinterface

### hw/rtl/dpb_cfg_if.sv
// register write channel
interface dpb_cfg_if import dpb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/dpb_cfg.sv
// configuration register file
module dpb_cfg import dpb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	dpb_cfg_if.sink cfg,
	output cfg_t    regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.inv_focal_x   <= RST_INV_FOCAL;
			regs_q.inv_focal_y   <= RST_INV_FOCAL;
			regs_q.cx            <= '0;
			regs_q.cy            <= '0;
			regs_q.pose_row_x    <= RST_POSE_X;
			regs_q.pose_row_y    <= RST_POSE_Y;
			regs_q.pose_row_z    <= RST_POSE_Z;
			regs_q.inv_avg_focal <= RST_INV_FOCAL;
			regs_q.spread_enable <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_INV_FOCAL_X:     regs_q.inv_focal_x   <= cfg.data[RECIP_W-1:0];
				REG_INV_FOCAL_Y:     regs_q.inv_focal_y   <= cfg.data[RECIP_W-1:0];
				REG_PRINCIPAL_POINT: begin
					regs_q.cx <= cfg.data[PP_W-1:0];
					regs_q.cy <= cfg.data[2*PP_W-1:PP_W];
				end
				REG_POSE_ROW_X:      regs_q.pose_row_x    <= cfg.data;
				REG_POSE_ROW_Y:      regs_q.pose_row_y    <= cfg.data;
				REG_POSE_ROW_Z:      regs_q.pose_row_z    <= cfg.data;
				REG_INV_AVG_FOCAL:   regs_q.inv_avg_focal <= cfg.data[RECIP_W-1:0];
				REG_SPREAD_ENABLE:   regs_q.spread_enable <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

### hw/rtl/dpb_cam.sv
// pixel filter and camera-space back-projection, stages 1 to 3
`include "depth_pixel_backprojection_core_defines.svh"

module dpb_cam import dpb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      regs,
	dpb_pixel_if.sink pixel,
	output logic      cam_valid,
	input  logic      cam_ready,
	output cam_t      cam
);

	logic v_s1, v_s2, v_s3;
	logic ld_s1, ld_s2, ld_s3;
	logic keep;

	logic signed [DIFF_W-1:0] dx, dy;
	logic signed [P1_W-1:0]   p1x, p1y;
	logic [SA_W-1:0]          sa;

	logic signed [P1_W-1:0] p1x_s1, p1y_s1;
	logic [SA_W-1:0]        sa_s1;
	logic [DEPTH_W-1:0]     d_s1;
	logic [3*COLOR_W-1:0]   rgb_s1;

	logic signed [P2_W-1:0] p2x_s2, p2y_s2;
	logic [S_W-1:0]         s_s2;
	logic [DEPTH_W-1:0]     d_s2;
	logic [3*COLOR_W-1:0]   rgb_s2;
	logic [SA_W-1:0]        sa_rnd;

	logic signed [XC_W-1:0] xc_s3, yc_s3;
	logic [SQ_W-1:0]        sq_s3;
	logic [DEPTH_W-1:0]     d_s3;
	logic [3*COLOR_W-1:0]   rgb_s3;
	logic [P2_W-1:0]        x_rnd, y_rnd;

	// a stage takes new data when empty or when its contents move on
	assign ld_s3       = !v_s3 || cam_ready;
	assign ld_s2       = !v_s2 || ld_s3;
	assign ld_s1       = !v_s1 || ld_s2;
	assign pixel.ready = ld_s1;

	assign keep = pixel.mask_bit && (pixel.depth_value != '0);

	assign dx  = $signed({2'b00, pixel.pixel_col, 4'b0000}) - $signed({2'b00, regs.cx});
	assign dy  = $signed({2'b00, pixel.pixel_row, 4'b0000}) - $signed({2'b00, regs.cy});
	assign p1x = dx * $signed({1'b0, regs.inv_focal_x});
	assign p1y = dy * $signed({1'b0, regs.inv_focal_y});
	// disabled spread is forced to zero at the source
	assign sa  = pixel.depth_value * (regs.spread_enable ? regs.inv_avg_focal : '0);

	assign sa_rnd = sa_s1 + S_RND;
	// round half away from zero: bias by one less for negative values
	assign x_rnd  = p2x_s2 + XY_RND - P2_W'(p2x_s2[P2_W-1]);
	assign y_rnd  = p2y_s2 + XY_RND - P2_W'(p2y_s2[P2_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= pixel.valid && keep;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && pixel.valid) begin
			p1x_s1 <= p1x;
			p1y_s1 <= p1y;
			sa_s1  <= sa;
			d_s1   <= pixel.depth_value;
			rgb_s1 <= {pixel.color_red, pixel.color_green, pixel.color_blue};
		end
		if (ld_s2 && v_s1) begin
			p2x_s2 <= p1x_s1 * $signed({1'b0, d_s1});
			p2y_s2 <= p1y_s1 * $signed({1'b0, d_s1});
			s_s2   <= sa_rnd[SA_W-1:S_SH];
			d_s2   <= d_s1;
			rgb_s2 <= rgb_s1;
		end
		if (ld_s3 && v_s2) begin
			xc_s3  <= $signed(x_rnd[XY_SH+XC_W-1:XY_SH]);
			yc_s3  <= $signed(y_rnd[XY_SH+XC_W-1:XY_SH]);
			sq_s3  <= s_s2 * s_s2;
			d_s3   <= d_s2;
			rgb_s3 <= rgb_s2;
		end
	end

	assign cam_valid  = v_s3;
	assign cam.xc     = xc_s3;
	assign cam.yc     = yc_s3;
	assign cam.d      = d_s3;
	assign cam.red    = rgb_s3[3*COLOR_W-1:2*COLOR_W];
	assign cam.green  = rgb_s3[2*COLOR_W-1:COLOR_W];
	assign cam.blue   = rgb_s3[COLOR_W-1:0];
	assign cam.sq_raw = sq_s3;

	`DPB_ASSERT_NEXT(a_reject_dropped, pixel.valid && pixel.ready && !keep, !v_s1, "rejected pixel entered the pipeline")
	`DPB_ASSERT_NOW(a_no_zero_depth, v_s3, d_s3 != '0, "zero depth reached stage 3")
	`DPB_ASSERT_NOW(a_full_backpressure, v_s1 && v_s2 && v_s3 && !cam_ready, !pixel.ready, "full pipeline took a pixel")
	`DPB_ASSERT_NEXT(a_stage_advance, v_s2 && ld_s3, v_s3, "stage 2 item lost on advance")

endmodule

### hw/rtl/dpb_xform.sv
// camera-to-world transform, spread rounding and output register, stages 4 to 6
module dpb_xform import dpb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        regs,
	input  logic        cam_valid,
	output logic        cam_ready,
	input  cam_t        cam,
	dpb_point_if.source point
);

	logic v_s4, v_s5, v_s6;
	logic ld_s4, ld_s5, ld_s6;

	logic [POSE_W-1:0] pose [NUM_ROWS];
	logic [ZC_W-1:0]   zc;
	logic [SQ_W-1:0]   sq_rnd;

	logic [SQR_W-1:0]          sq_s4;
	logic [3*COLOR_W-1:0]      rgb_s4;
	logic [SPREAD_W-1:0]       spread_s5;
	logic [3*COLOR_W-1:0]      rgb_s5;
	logic [SPREAD_W-1:0]       spread_s6;
	logic [3*COLOR_W-1:0]      rgb_s6;
	logic signed [WORLD_W-1:0] world_s6 [NUM_ROWS];

	assign pose[0] = regs.pose_row_x;
	assign pose[1] = regs.pose_row_y;
	assign pose[2] = regs.pose_row_z;

	assign ld_s6     = !v_s6 || point.ready;
	assign ld_s5     = !v_s5 || ld_s6;
	assign ld_s4     = !v_s4 || ld_s5;
	assign cam_ready = ld_s4;

	assign zc     = {cam.d, 8'h00};
	assign sq_rnd = cam.sq_raw + SQ_RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld_s4) v_s4 <= cam_valid;
			if (ld_s5) v_s5 <= v_s4;
			if (ld_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s4 && cam_valid) begin
			sq_s4  <= sq_rnd[SQ_W-1:SQ_SH];
			rgb_s4 <= {cam.red, cam.green, cam.blue};
		end
		if (ld_s5 && v_s4) begin
			spread_s5 <= (|sq_s4[SQR_W-1:SPREAD_W]) ? '1 : sq_s4[SPREAD_W-1:0];
			rgb_s5    <= rgb_s4;
		end
		if (ld_s6 && v_s5) begin
			spread_s6 <= spread_s5;
			rgb_s6    <= rgb_s5;
		end
	end

	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		logic signed [PR_W-1:0]  mx_s4, my_s4;
		logic signed [PZ_W-1:0]  mz_s4;
		logic signed [ACC_W-1:0] tt;
		logic signed [ACC_W-1:0] acc_s5;
		logic [ACC_W-1:0]        acc_rnd;
		logic signed [WR_W-1:0]  w;
		logic                    fits;

		assign tt      = ACC_W'($signed(pose[r][4*ENT_W-1:3*ENT_W])) <<< T_SH;
		assign acc_rnd = acc_s5 + W_RND - ACC_W'(acc_s5[ACC_W-1]);
		assign w       = $signed(acc_rnd[ACC_W-1:W_SH]);
		// value fits when the bits above the 32-bit sign all match it
		assign fits    = (w[WR_W-1:WORLD_W-1] == '0) || (w[WR_W-1:WORLD_W-1] == '1);

		always_ff @(posedge clk) begin
			if (ld_s4 && cam_valid) begin
				mx_s4 <= $signed(pose[r][ENT_W-1:0]) * cam.xc;
				my_s4 <= $signed(pose[r][2*ENT_W-1:ENT_W]) * cam.yc;
				mz_s4 <= $signed(pose[r][3*ENT_W-1:2*ENT_W]) * $signed({1'b0, zc});
			end
			if (ld_s5 && v_s4) begin
				acc_s5 <= ACC_W'(mx_s4) + ACC_W'(my_s4) + ACC_W'(mz_s4) + tt;
			end
			if (ld_s6 && v_s5) begin
				if (fits) begin
					world_s6[r] <= w[WORLD_W-1:0];
				end else if (w[WR_W-1]) begin
					world_s6[r] <= {1'b1, {(WORLD_W-1){1'b0}}};
				end else begin
					world_s6[r] <= {1'b0, {(WORLD_W-1){1'b1}}};
				end
			end
		end
	end

	assign point.valid     = v_s6;
	assign point.world_x   = world_s6[0];
	assign point.world_y   = world_s6[1];
	assign point.world_z   = world_s6[2];
	assign point.out_red   = rgb_s6[3*COLOR_W-1:2*COLOR_W];
	assign point.out_green = rgb_s6[2*COLOR_W-1:COLOR_W];
	assign point.out_blue  = rgb_s6[COLOR_W-1:0];
	assign point.spread_sq = spread_s6;

endmodule

### hw/rtl/depth_pixel_backprojection_core.sv
// top level of the depth pixel back-projection core
//
//   channel   direction  handshake      contents
//   pixel     in         valid/ready    column, row, depth, mask, colour
//   point     out        valid/ready    world x/y/z, colour, spread term
//   cfg       in         valid/ready    register index, write data
//
// one pixel is accepted per cycle while point does not stall; a kept pixel
// appears at point after passing the six register stages of the datapath
// masked or zero-depth pixels are taken at the same rate and produce nothing
// reset clears the stage valid bits and loads the register defaults
// a stall at point backs up stage by stage; empty stages keep filling
module depth_pixel_backprojection_core import dpb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dpb_pixel_if.sink   pixel,
	dpb_point_if.source point,
	dpb_cfg_if.sink     cfg
);

	cfg_t regs;
	cam_t cam;
	logic cam_valid;
	logic cam_ready;

	dpb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	dpb_cam u_cam (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.pixel     (pixel),
		.cam_valid (cam_valid),
		.cam_ready (cam_ready),
		.cam       (cam)
	);

	dpb_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.cam_valid (cam_valid),
		.cam_ready (cam_ready),
		.cam       (cam),
		.point     (point)
	);

endmodule
